@@ src/ece_pkg.sv @@
package ece_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TW        = FRAC_BITS + 1;
  localparam int OW        = FRAC_BITS + 2;
  localparam int CODE_W    = 5;
  localparam int TDW_IN    = ((TW + 7) / 8) * 8;
  localparam int TDW_OUT   = ((OW + 7) / 8) * 8;
  localparam int QW        = 24;
  localparam int NSTAGE    = 11;

  typedef logic signed [QW-1:0] q_t;

  localparam longint ONE_L  = longint'(1) <<< FRAC_BITS;
  localparam q_t     ONE    = q_t'(ONE_L);
  localparam q_t     HALF   = q_t'(ONE_L / 2);

  // rounds a 32-fraction-bit constant to the working fraction width
  function automatic longint qk(input longint q32);
    return (q32 + (longint'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  endfunction

  localparam q_t S_BACK  = q_t'(qk(64'sd7308230452));
  localparam q_t S_BACK2 = q_t'(qk(64'sd11145051439));

  // 2^-g polynomial
  localparam q_t EK0 = q_t'(qk(64'sd5726720));
  localparam q_t EK1 = q_t'(qk(64'sd41309550));
  localparam q_t EK2 = q_t'(qk(64'sd238388332));
  localparam q_t EK3 = q_t'(qk(64'sd1031764991));
  localparam q_t EK4 = q_t'(qk(64'sd2977044472));

  // sin(pi/2 * y) polynomial in y^2
  localparam q_t SK0 = q_t'(qk(64'sd20107981));
  localparam q_t SK1 = q_t'(qk(64'sd342277223));
  localparam q_t SK2 = q_t'(qk(64'sd2774394673));
  localparam q_t SK3 = q_t'(qk(64'sd6746518852));

  typedef enum logic [CODE_W-1:0] {
    C_LINEAR       = 5'd0,
    C_QUAD_IN      = 5'd1,
    C_QUAD_OUT     = 5'd2,
    C_QUAD_INOUT   = 5'd3,
    C_QUAD_OUTIN   = 5'd4,
    C_QUART_INOUT  = 5'd5,
    C_QUART_OUTIN  = 5'd6,
    C_CUBIC_INOUT  = 5'd7,
    C_CUBIC_OUTIN  = 5'd8,
    C_BOUNCE_IN    = 5'd9,
    C_BOUNCE_OUT   = 5'd10,
    C_ELASTIC_IN   = 5'd11,
    C_ELASTIC_OUT  = 5'd12,
    C_BACK_IN      = 5'd13,
    C_BACK_OUT     = 5'd14,
    C_BACK_INOUT   = 5'd15,
    C_BACK_OUTIN   = 5'd16
  } curve_t;

  // fixed-point multiply, rounded half away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] p;
    logic [2*QW-1:0] r;
    ma = a[QW-1] ? QW'(-a) : QW'(a);
    mb = b[QW-1] ? QW'(-b) : QW'(b);
    p  = ma * mb;
    r  = (p + ((2*QW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (a[QW-1] ^ b[QW-1]) ? -q_t'(r[QW-1:0]) : q_t'(r[QW-1:0]);
  endfunction

  // right shift rounded half away from zero
  function automatic q_t rshn(input q_t a, input logic [3:0] n);
    logic [QW-1:0] m;
    logic [QW-1:0] r;
    m = a[QW-1] ? QW'(-a) : QW'(a);
    r = (m + ((QW'(1) << n) >> 1)) >> n;
    return a[QW-1] ? -q_t'(r) : q_t'(r);
  endfunction

endpackage

@@ src/ece_poly.sv @@
module ece_poly (
  input  logic                        clk,
  input  logic [ece_pkg::NSTAGE-1:0]  en,
  input  logic [ece_pkg::CODE_W-1:0]  code,
  input  logic [ece_pkg::TW-1:0]      t,
  output ece_pkg::q_t                 value
);

  localparam int F  = ece_pkg::FRAC_BITS;
  localparam int TW = ece_pkg::TW;
  localparam int SW = F + 2;
  localparam longint ONE_L = ece_pkg::ONE_L;

  localparam ece_pkg::q_t B_ADD1 = ece_pkg::q_t'((3 * ONE_L) / 4);
  localparam ece_pkg::q_t B_ADD2 = ece_pkg::q_t'((15 * ONE_L) / 16);
  localparam ece_pkg::q_t B_ADD3 = ece_pkg::q_t'((63 * ONE_L) / 64);

  typedef enum logic [2:0] {
    U_IN_QUAD, U_OUT_QUAD, U_IN_QUART, U_OUT_QUART,
    U_IN_CUBIC, U_OUT_CUBIC, U_IN_BACK, U_OUT_BACK
  } unit_t;

  // stage 1 prep
  unit_t       kind_c;
  logic        two_c;
  logic        hi_c;
  logic        is_in;
  ece_pkg::q_t s_c;
  ece_pkg::q_t tq;
  ece_pkg::q_t x_c;
  ece_pkg::q_t u_c;
  ece_pkg::q_t xb_c;
  ece_pkg::q_t w_c;
  ece_pkg::q_t bd_c;
  ece_pkg::q_t badd_c;

  unit_t       kind1, kind2, kind3;
  logic        two1, two2, two3;
  logic        hi1, hi2, hi3;
  ece_pkg::q_t a1, b1, z1, sp1, d1;
  logic [ece_pkg::CODE_W-1:0] code1, code2, code3;
  logic [TW-1:0] t1, t2, t3;
  logic [SW-1:0] bm1;
  ece_pkg::q_t   badd1, badd2;
  logic          bfull1, bfull2;
  logic          binv1, binv2;

  ece_pkg::q_t   p2, q2, z2, d2;
  logic [2*SW-1:0] bsq;
  logic [TW-1:0] bterm2;

  ece_pkg::q_t   c3;
  ece_pkg::q_t   r3;
  ece_pkg::q_t   bo_c;
  ece_pkg::q_t   bv3;

  ece_pkg::q_t   res_c;
  ece_pkg::q_t   pv_c;
  ece_pkg::q_t   v4_next;
  ece_pkg::q_t   vd [4:9];

  always_comb begin
    tq    = ece_pkg::q_t'(t);
    hi_c  = tq >= ece_pkg::HALF;
    kind_c = U_IN_QUAD;
    two_c  = 1'b0;
    s_c    = '0;
    case (code)
      ece_pkg::C_QUAD_IN:     kind_c = U_IN_QUAD;
      ece_pkg::C_QUAD_OUT:    kind_c = U_OUT_QUAD;
      ece_pkg::C_QUAD_INOUT: begin
        two_c = 1'b1; kind_c = hi_c ? U_OUT_QUAD : U_IN_QUAD;
      end
      ece_pkg::C_QUAD_OUTIN: begin
        two_c = 1'b1; kind_c = hi_c ? U_IN_QUAD : U_OUT_QUAD;
      end
      ece_pkg::C_QUART_INOUT: begin
        two_c = 1'b1; kind_c = hi_c ? U_OUT_QUART : U_IN_QUART;
      end
      ece_pkg::C_QUART_OUTIN: begin
        two_c = 1'b1; kind_c = hi_c ? U_IN_QUART : U_OUT_QUART;
      end
      ece_pkg::C_CUBIC_INOUT: begin
        two_c = 1'b1; kind_c = hi_c ? U_OUT_CUBIC : U_IN_CUBIC;
      end
      ece_pkg::C_CUBIC_OUTIN: begin
        two_c = 1'b1; kind_c = hi_c ? U_IN_CUBIC : U_OUT_CUBIC;
      end
      ece_pkg::C_BACK_IN: begin
        kind_c = U_IN_BACK; s_c = ece_pkg::S_BACK;
      end
      ece_pkg::C_BACK_OUT: begin
        kind_c = U_OUT_BACK; s_c = ece_pkg::S_BACK;
      end
      ece_pkg::C_BACK_INOUT: begin
        two_c = 1'b1; s_c = ece_pkg::S_BACK2;
        kind_c = hi_c ? U_OUT_BACK : U_IN_BACK;
      end
      ece_pkg::C_BACK_OUTIN: begin
        two_c = 1'b1; s_c = ece_pkg::S_BACK;
        kind_c = hi_c ? U_IN_BACK : U_OUT_BACK;
      end
      default: kind_c = U_IN_QUAD;
    endcase

    // two-piece curves run on 2t, or 2t-1 in the second half
    if (two_c) begin
      x_c = hi_c ? (tq <<< 1) - ece_pkg::ONE : (tq <<< 1);
    end else begin
      x_c = tq;
    end
    u_c   = x_c - ece_pkg::ONE;
    is_in = (kind_c == U_IN_QUAD) || (kind_c == U_IN_QUART) ||
            (kind_c == U_IN_CUBIC) || (kind_c == U_IN_BACK);

    // bounce out: 7.5625*(x-c)^2 as (11x - 11c)^2 / 16
    xb_c = (code == ece_pkg::C_BOUNCE_IN) ? ece_pkg::ONE - tq : tq;
    w_c  = ece_pkg::q_t'(xb_c * 11);
    if (w_c < ece_pkg::q_t'(4 * ONE_L)) begin
      bd_c = w_c; badd_c = '0;
    end else if (w_c < ece_pkg::q_t'(8 * ONE_L)) begin
      bd_c = w_c - ece_pkg::q_t'(6 * ONE_L); badd_c = B_ADD1;
    end else if (w_c < ece_pkg::q_t'(10 * ONE_L)) begin
      bd_c = w_c - ece_pkg::q_t'(9 * ONE_L); badd_c = B_ADD2;
    end else begin
      bd_c = w_c - ece_pkg::q_t'((21 * ONE_L) / 2); badd_c = B_ADD3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      kind1  <= kind_c;
      two1   <= two_c;
      hi1    <= hi_c;
      a1     <= (is_in || kind_c == U_OUT_QUAD) ? x_c : u_c;
      b1     <= is_in ? x_c :
                (kind_c == U_OUT_QUAD) ? (ece_pkg::q_t'(2 * ONE_L) - x_c) : u_c;
      z1     <= is_in ? x_c : u_c;
      sp1    <= s_c + ece_pkg::ONE;
      d1     <= is_in ? -s_c : s_c;
      code1  <= code;
      t1     <= t;
      bm1    <= bd_c[ece_pkg::QW-1] ? SW'(-bd_c) : SW'(bd_c);
      badd1  <= badd_c;
      bfull1 <= xb_c >= ece_pkg::ONE;
      binv1  <= code == ece_pkg::C_BOUNCE_IN;
    end
  end

  assign bsq = (2*SW)'(bm1) * (2*SW)'(bm1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2     <= ece_pkg::qmul(a1, b1);
      q2     <= ece_pkg::qmul(sp1, z1);
      z2     <= z1;
      d2     <= d1;
      kind2  <= kind1;
      two2   <= two1;
      hi2    <= hi1;
      code2  <= code1;
      t2     <= t1;
      bterm2 <= TW'((bsq + ((2*SW)'(1) << (F + 3))) >> (F + 4));
      badd2  <= badd1;
      bfull2 <= bfull1;
      binv2  <= binv1;
    end
  end

  always_comb begin
    case (kind2)
      U_IN_QUART, U_OUT_QUART: c3 = p2;
      U_IN_CUBIC, U_OUT_CUBIC: c3 = z2;
      U_IN_BACK, U_OUT_BACK:   c3 = q2 + d2;
      default:                 c3 = ece_pkg::ONE;
    endcase
    bo_c = bfull2 ? ece_pkg::ONE : ece_pkg::q_t'(bterm2) + badd2;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r3    <= ece_pkg::qmul(p2, c3);
      kind3 <= kind2;
      two3  <= two2;
      hi3   <= hi2;
      code3 <= code2;
      t3    <= t2;
      bv3   <= binv2 ? ece_pkg::ONE - bo_c : bo_c;
    end
  end

  always_comb begin
    case (kind3)
      U_OUT_QUART:             res_c = ece_pkg::ONE - r3;
      U_OUT_CUBIC, U_OUT_BACK: res_c = r3 + ece_pkg::ONE;
      default:                 res_c = r3;
    endcase
    if (two3) begin
      pv_c = ece_pkg::rshn(res_c, 4'd1) + (hi3 ? ece_pkg::HALF : ece_pkg::q_t'(0));
    end else begin
      pv_c = res_c;
    end
    case (code3)
      ece_pkg::C_LINEAR:                            v4_next = ece_pkg::q_t'(t3);
      ece_pkg::C_BOUNCE_IN, ece_pkg::C_BOUNCE_OUT:  v4_next = bv3;
      ece_pkg::C_QUAD_IN, ece_pkg::C_QUAD_OUT, ece_pkg::C_QUAD_INOUT,
      ece_pkg::C_QUAD_OUTIN, ece_pkg::C_QUART_INOUT, ece_pkg::C_QUART_OUTIN,
      ece_pkg::C_CUBIC_INOUT, ece_pkg::C_CUBIC_OUTIN, ece_pkg::C_BACK_IN,
      ece_pkg::C_BACK_OUT, ece_pkg::C_BACK_INOUT, ece_pkg::C_BACK_OUTIN:
        v4_next = pv_c;
      default:                                      v4_next = '0;
    endcase
  end

  // delay to line up with the elastic lane
  always_ff @(posedge clk) begin
    if (en[4]) begin
      vd[4] <= v4_next;
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  assign value = vd[9];

endmodule

@@ src/ece_elastic.sv @@
module ece_elastic (
  input  logic                        clk,
  input  logic [ece_pkg::NSTAGE-1:0]  en,
  input  logic [ece_pkg::CODE_W-1:0]  code,
  input  logic [ece_pkg::TW-1:0]      t,
  output ece_pkg::q_t                 value
);

  localparam int F  = ece_pkg::FRAC_BITS;
  localparam int TW = ece_pkg::TW;
  localparam int EW = F + 4;
  localparam int NW = F + 5;
  localparam int SW = F + 2;
  localparam int PW = F + 4;
  localparam longint ONE_L  = ece_pkg::ONE_L;
  localparam longint M3     = 3 * ONE_L;
  localparam longint PH_OFF = 12 * ONE_L - (3 * ONE_L) / 4;
  localparam longint RECIP3 = ((longint'(1) <<< (SW + 1)) + 2) / 3;

  typedef struct packed {
    logic el;
    logic out;
    logic zero;
    logic full;
  } flag_t;

  flag_t         fl_c;
  logic [TW-1:0] tt_c;
  logic [EW-1:0] e_c;
  logic [NW-1:0] nn_c;

  flag_t         fl [1:9];
  logic [F-1:0]  g_s [1:5];
  logic [3:0]    ip_s [1:6];
  logic [NW-1:0] nn1;

  ece_pkg::q_t   er2, er3, er4, er5, er6, er7, er8;

  logic [NW-1:0] base_c;
  logic [SW-1:0] m2;

  logic [PW-1:0] p_c;
  logic [1:0]    qq_c;
  logic [SW-1:0] rem_c;
  logic [SW-1:0] v_c;
  logic [2*SW-1:0] y3prod;
  logic [TW-1:0] y0_c;

  logic [TW-1:0] y_s [3:7];
  logic [1:0]    q_s [3:7];
  ece_pkg::q_t   y2_s [4:6];
  ece_pkg::q_t   sr5, sr6, sr7, sn8, prod9;
  ece_pkg::q_t   sq8_c;

  always_comb begin
    fl_c.out  = code == ece_pkg::C_ELASTIC_OUT;
    fl_c.el   = fl_c.out || (code == ece_pkg::C_ELASTIC_IN);
    fl_c.zero = t == '0;
    fl_c.full = t >= TW'(ONE_L);
    tt_c      = fl_c.out ? t : TW'(ONE_L) - t;
    e_c       = EW'(EW'(tt_c) * EW'(10));
    // phase plus four periods' worth, always positive
    nn_c      = fl_c.out ? NW'(PH_OFF) + NW'(e_c) : NW'(PH_OFF) - NW'(e_c);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fl[1]   <= fl_c;
      g_s[1]  <= e_c[F-1:0];
      ip_s[1] <= e_c[EW-1:F];
      nn1     <= nn_c;
    end
    for (int k = 2; k <= 9; k++) begin
      if (en[k]) begin
        fl[k] <= fl[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        g_s[k] <= g_s[k-1];
      end
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        ip_s[k] <= ip_s[k-1];
      end
    end
  end

  // decay 2^-e: horner chain, one multiply per stage
  always_ff @(posedge clk) begin
    if (en[2]) er2 <= ece_pkg::EK1 + ece_pkg::qmul(ece_pkg::q_t'(g_s[1]), -ece_pkg::EK0);
    if (en[3]) er3 <= -ece_pkg::EK2 + ece_pkg::qmul(ece_pkg::q_t'(g_s[2]), er2);
    if (en[4]) er4 <= ece_pkg::EK3 + ece_pkg::qmul(ece_pkg::q_t'(g_s[3]), er3);
    if (en[5]) er5 <= -ece_pkg::EK4 + ece_pkg::qmul(ece_pkg::q_t'(g_s[4]), er4);
    if (en[6]) er6 <= ece_pkg::ONE + ece_pkg::qmul(ece_pkg::q_t'(g_s[5]), er5);
    if (en[7]) er7 <= ece_pkg::rshn(er6, ip_s[6]);
    if (en[8]) er8 <= er7;
  end

  // reduce modulo one period
  always_comb begin
    base_c = '0;
    for (int j = 1; j < 8; j++) begin
      if (nn1 >= NW'(j * M3)) begin
        base_c = NW'(j * M3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m2 <= SW'(nn1 - base_c);
    end
  end

  // quarter-wave split and y = (rem + 1) / 3 by reciprocal
  always_comb begin
    p_c = {m2, 2'b00};
    if (p_c >= PW'(3 * M3)) begin
      qq_c = 2'd3;
    end else if (p_c >= PW'(2 * M3)) begin
      qq_c = 2'd2;
    end else if (p_c >= PW'(M3)) begin
      qq_c = 2'd1;
    end else begin
      qq_c = 2'd0;
    end
    rem_c  = SW'(p_c - PW'(longint'(qq_c) * M3));
    v_c    = rem_c + SW'(1);
    y3prod = (2*SW)'(v_c) * (2*SW)'(RECIP3);
    y0_c   = TW'(y3prod >> (SW + 1));
  end

  assign sq8_c = ece_pkg::qmul(ece_pkg::q_t'(y_s[7]), sr7);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      y_s[3] <= qq_c[0] ? TW'(ONE_L) - y0_c : y0_c;
      q_s[3] <= qq_c;
    end
    for (int k = 4; k <= 7; k++) begin
      if (en[k]) begin
        y_s[k] <= y_s[k-1];
        q_s[k] <= q_s[k-1];
      end
    end
    if (en[4]) y2_s[4] <= ece_pkg::qmul(ece_pkg::q_t'(y_s[3]), ece_pkg::q_t'(y_s[3]));
    if (en[5]) y2_s[5] <= y2_s[4];
    if (en[6]) y2_s[6] <= y2_s[5];
    if (en[5]) sr5 <= ece_pkg::SK1 + ece_pkg::qmul(y2_s[4], -ece_pkg::SK0);
    if (en[6]) sr6 <= -ece_pkg::SK2 + ece_pkg::qmul(y2_s[5], sr5);
    if (en[7]) sr7 <= ece_pkg::SK3 + ece_pkg::qmul(y2_s[6], sr6);
    if (en[8]) sn8 <= q_s[7][1] ? -sq8_c : sq8_c;
    if (en[9]) prod9 <= ece_pkg::qmul(er8, sn8);
  end

  always_comb begin
    if (!fl[9].el) begin
      value = '0;
    end else if (fl[9].zero) begin
      value = '0;
    end else if (fl[9].full) begin
      value = ece_pkg::ONE;
    end else if (fl[9].out) begin
      value = prod9 + ece_pkg::ONE;
    end else begin
      value = -prod9;
    end
  end

endmodule

@@ src/easing_curve_evaluator.sv @@
// Easing curve evaluator: each item carries a curve code in tuser and a progress value
// (unsigned, 16 fraction bits, 1.0 = 0x10000, larger values act as 1.0) in tdata, and
// yields one eased value (signed, 2 integer and 16 fraction bits) on the output stream.
// Codes 0..16 select linear, quad, quart, cubic, bounce, elastic and back curves; other
// codes give 0. One item is taken per clock unless back-pressure has filled all 11 register
// stages. The depth is set by the elastic path (a fifth-order decay polynomial and a
// seventh-order sine polynomial, one multiply per stage). Back-pressure stalls only the
// occupied stages, so bubbles close up while the output waits.
module easing_curve_evaluator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ece_pkg::TDW_IN-1:0]    s_axis_tdata,   // [16:0] progress
  input  logic [ece_pkg::CODE_W-1:0]    s_axis_tuser,   // [4:0] func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ece_pkg::TDW_OUT-1:0]   m_axis_tdata    // [17:0] eased
);

  localparam int NS = ece_pkg::NSTAGE;
  localparam int TW = ece_pkg::TW;
  localparam int OW = ece_pkg::OW;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [ece_pkg::CODE_W-1:0] code0;
  logic [TW-1:0]              t0;

  ece_pkg::q_t poly_v;
  ece_pkg::q_t elas_v;
  ece_pkg::q_t sum_c;
  logic [OW-1:0] eased_next;
  logic [OW-1:0] eased;

  // a stage loads when empty or when its item moves on
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      code0 <= s_axis_tuser;
      t0    <= (s_axis_tdata[TW-1:0] > TW'(ece_pkg::ONE_L)) ? TW'(ece_pkg::ONE_L)
                                                             : s_axis_tdata[TW-1:0];
    end
  end

  ece_poly u_poly (
    .clk   (clk),
    .en    (en),
    .code  (code0),
    .t     (t0),
    .value (poly_v)
  );

  ece_elastic u_elastic (
    .clk   (clk),
    .en    (en),
    .code  (code0),
    .t     (t0),
    .value (elas_v)
  );

  // each lane gives zero for codes it does not own
  always_comb begin
    sum_c = poly_v + elas_v;
    if (sum_c < -ece_pkg::q_t'(2 * ece_pkg::ONE_L)) begin
      eased_next = OW'(-ece_pkg::q_t'(2 * ece_pkg::ONE_L));
    end else if (sum_c > ece_pkg::q_t'(2 * ece_pkg::ONE_L - 1)) begin
      eased_next = OW'(ece_pkg::q_t'(2 * ece_pkg::ONE_L - 1));
    end else begin
      eased_next = OW'(sum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      eased <= eased_next;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {{(ece_pkg::TDW_OUT - OW){1'b0}}, eased};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is taken");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted item missing from first stage");

endmodule
